>>> src/smcd_pkg.sv
// Package: shared constants, types and codes for the serial motor command decoder.
`timescale 1ns / 1ps

package smcd_pkg;

   localparam int LINE_CAPACITY = 40;
   localparam int CNT_W         = $clog2(LINE_CAPACITY);
   localparam logic [CNT_W-1:0] LINE_LIMIT = CNT_W'(LINE_CAPACITY - 1);

   localparam int BYTE_W  = 8;
   localparam int SPEED_W = 9;
   localparam int CODE_W  = 3;
   localparam int ACCUM_W = 9;

   localparam logic [ACCUM_W-1:0] ACCUM_SAT = 9'd256;
   localparam logic [7:0]         SPEED_MAX = 8'd255;

   localparam logic [BYTE_W-1:0] CH_NUL    = 8'd0;
   localparam logic [BYTE_W-1:0] CH_TAB    = 8'd9;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'd10;
   localparam logic [BYTE_W-1:0] CH_VT     = 8'd11;
   localparam logic [BYTE_W-1:0] CH_FF     = 8'd12;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'd13;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'd32;
   localparam logic [BYTE_W-1:0] CH_PLUS   = 8'd43;
   localparam logic [BYTE_W-1:0] CH_MINUS  = 8'd45;
   localparam logic [BYTE_W-1:0] CH_ZERO   = 8'd48;
   localparam logic [BYTE_W-1:0] CH_NINE   = 8'd57;

   localparam logic [BYTE_W-1:0] ACT_FORWARD    = 8'd102; // f
   localparam logic [BYTE_W-1:0] ACT_BACKWARD   = 8'd98;  // b
   localparam logic [BYTE_W-1:0] ACT_LEFT       = 8'd108; // l
   localparam logic [BYTE_W-1:0] ACT_RIGHT      = 8'd114; // r
   localparam logic [BYTE_W-1:0] ACT_SPIN_LEFT  = 8'd101; // e
   localparam logic [BYTE_W-1:0] ACT_SPIN_RIGHT = 8'd113; // q
   localparam logic [BYTE_W-1:0] ACT_STOP       = 8'd115; // s

   typedef enum logic [CODE_W-1:0] {
      CMD_FORWARD    = 3'd0,
      CMD_BACKWARD   = 3'd1,
      CMD_LEFT       = 3'd2,
      CMD_RIGHT      = 3'd3,
      CMD_SPIN_LEFT  = 3'd4,
      CMD_SPIN_RIGHT = 3'd5,
      CMD_STOP       = 3'd6
   } cmd_code_type;

   typedef enum logic [2:0] {
      PH_SKIP   = 3'b001,
      PH_DIGITS = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   // Parser to mixer: one completed line per transfer of a newline.
   typedef struct packed {
      logic              fire;
      logic              long_enough;
      logic [BYTE_W-1:0] action;
      logic [7:0]        speed;
   } line_cmd_type;

endpackage

>>> src/smcd_if.sv
// Interfaces: request byte channel and response command channel.
`timescale 1ns / 1ps

interface smcd_req_if;
   import smcd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface smcd_rsp_if;
   import smcd_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CODE_W-1:0]         command_code;
   logic signed [SPEED_W-1:0] drive_a_speed;
   logic signed [SPEED_W-1:0] drive_b_speed;
   logic signed [SPEED_W-1:0] drive_c_speed;
   logic signed [SPEED_W-1:0] drive_d_speed;
   modport source (output valid, output command_code, output drive_a_speed,
                   output drive_b_speed, output drive_c_speed, output drive_d_speed,
                   input ready);
   modport sink   (input valid, input command_code, input drive_a_speed,
                   input drive_b_speed, input drive_c_speed, input drive_d_speed,
                   output ready);
endinterface

>>> src/smcd_parser.sv
// Line parser: input byte register and per-line decode state.
`timescale 1ns / 1ps

module smcd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [smcd_pkg::BYTE_W-1:0] in_byte,
   output logic                  in_ready,
   input  logic                  down_ready,
   output smcd_pkg::line_cmd_type line_cmd
);
   import smcd_pkg::*;

   logic              byte_valid_ff, byte_valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [CNT_W-1:0]  stored_count_ff, stored_count_in;
   logic [CNT_W-1:0]  text_length_ff, text_length_in;
   logic              text_ended_ff, text_ended_in;
   logic [BYTE_W-1:0] action_ff, action_in;
   phase_type         phase_ff, phase_in;
   logic              negative_ff, negative_in;
   logic [ACCUM_W-1:0] accum_ff, accum_in;

   logic              advance;
   logic              is_digit, is_blank, is_sign;
   logic [11:0]       accum_next;

   assign advance  = byte_valid_ff && down_ready;
   assign in_ready = !byte_valid_ff || down_ready;

   assign is_digit = (byte_ff >= CH_ZERO) && (byte_ff <= CH_NINE);
   assign is_blank = (byte_ff == CH_SPACE) || (byte_ff == CH_TAB) ||
                     (byte_ff == CH_VT) || (byte_ff == CH_FF);
   assign is_sign  = (byte_ff == CH_PLUS) || (byte_ff == CH_MINUS);
   assign accum_next = 12'(accum_ff) * 12'd10 + 12'(byte_ff - CH_ZERO);

   always_comb begin
      line_cmd.fire        = advance && (byte_ff == CH_LF);
      line_cmd.long_enough = text_length_ff >= CNT_W'(2);
      line_cmd.action      = action_ff;
      if (negative_ff) begin
         line_cmd.speed = 8'd0;
      end else if (accum_ff > ACCUM_W'(SPEED_MAX)) begin
         line_cmd.speed = SPEED_MAX;
      end else begin
         line_cmd.speed = accum_ff[7:0];
      end
   end

   always_comb begin
      byte_valid_in   = byte_valid_ff;
      byte_in         = byte_ff;
      stored_count_in = stored_count_ff;
      text_length_in  = text_length_ff;
      text_ended_in   = text_ended_ff;
      action_in       = action_ff;
      phase_in        = phase_ff;
      negative_in     = negative_ff;
      accum_in        = accum_ff;

      if (in_ready) begin
         byte_valid_in = in_valid;
         byte_in       = in_byte;
      end

      if (advance) begin
         if (byte_ff == CH_LF) begin
            stored_count_in = '0;
            text_length_in  = '0;
            text_ended_in   = 1'b0;
            action_in       = '0;
            phase_in        = PH_SKIP;
            negative_in     = 1'b0;
            accum_in        = '0;
         end else if (byte_ff != CH_CR && stored_count_ff < LINE_LIMIT) begin
            stored_count_in = stored_count_ff + CNT_W'(1);
            if (!text_ended_ff) begin
               if (byte_ff == CH_NUL) begin
                  text_ended_in = 1'b1;
               end else begin
                  text_length_in = text_length_ff + CNT_W'(1);
                  if (text_length_ff == '0) begin
                     action_in = byte_ff;
                  end else begin
                     case (phase_ff)
                        PH_SKIP: begin
                           if (is_sign) begin
                              negative_in = (byte_ff == CH_MINUS);
                              phase_in    = PH_DIGITS;
                           end else if (is_digit) begin
                              phase_in = PH_DIGITS;
                              accum_in = (accum_next > 12'(ACCUM_SAT)) ? ACCUM_SAT
                                                                       : accum_next[8:0];
                           end else if (!is_blank) begin
                              phase_in = PH_DONE;
                           end
                        end
                        PH_DIGITS: begin
                           if (is_digit) begin
                              accum_in = (accum_next > 12'(ACCUM_SAT)) ? ACCUM_SAT
                                                                       : accum_next[8:0];
                           end else begin
                              phase_in = PH_DONE;
                           end
                        end
                        default: phase_in = phase_ff;
                     endcase
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff   <= 1'b0;
         stored_count_ff <= '0;
         text_length_ff  <= '0;
         text_ended_ff   <= 1'b0;
         action_ff       <= '0;
         phase_ff        <= PH_SKIP;
         negative_ff     <= 1'b0;
         accum_ff        <= '0;
      end else begin
         byte_valid_ff   <= byte_valid_in;
         stored_count_ff <= stored_count_in;
         text_length_ff  <= text_length_in;
         text_ended_ff   <= text_ended_in;
         action_ff       <= action_in;
         phase_ff        <= phase_in;
         negative_ff     <= negative_in;
         accum_ff        <= accum_in;
      end
      byte_ff <= byte_in;
   end

`ifndef SYNTHESIS
   a_text_within_stored: assert property (@(posedge clock) disable iff (reset)
      text_length_ff <= stored_count_ff) else $error("text length exceeds stored count");
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      stored_count_ff <= LINE_LIMIT) else $error("stored count past line limit");
   a_newline_clears: assert property (@(posedge clock) disable iff (reset)
      line_cmd.fire |=> (stored_count_ff == '0 && accum_ff == '0 && !negative_ff))
      else $error("line state not cleared after newline");
`endif

endmodule

>>> src/smcd_mixer.sv
// Mixer: repeat filter, motor mixing table and response register.
`timescale 1ns / 1ps

module smcd_mixer (
   input  logic                   clock,
   input  logic                   reset,
   input  smcd_pkg::line_cmd_type line_cmd,
   output logic                   up_ready,
   smcd_rsp_if.source             rsp
);
   import smcd_pkg::*;

   logic                      out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]         code_ff, code_in;
   logic signed [SPEED_W-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [BYTE_W-1:0]         last_action_ff, last_action_in;
   logic [7:0]                last_speed_ff, last_speed_in;

   logic                      known, emit;
   cmd_code_type              code;
   logic signed [SPEED_W-1:0] s_pos, s_neg, q_pos, q_neg;
   logic signed [SPEED_W-1:0] a, b, c, d;

   assign up_ready = !out_valid_ff || rsp.ready;

   assign s_pos = $signed({1'b0, line_cmd.speed});
   assign s_neg = -s_pos;
   assign q_pos = $signed({3'b000, line_cmd.speed[7:2]});
   assign q_neg = -q_pos;

   always_comb begin
      known = 1'b1;
      code  = CMD_STOP;
      a = '0; b = '0; c = '0; d = '0;
      case (line_cmd.action)
         ACT_FORWARD:    begin code = CMD_FORWARD;    a = s_neg; b = s_neg; c = s_neg; d = s_pos; end
         ACT_BACKWARD:   begin code = CMD_BACKWARD;   a = s_pos; b = s_pos; c = s_pos; d = s_neg; end
         ACT_LEFT:       begin code = CMD_LEFT;       a = q_neg; b = q_neg; c = s_neg; d = s_pos; end
         ACT_RIGHT:      begin code = CMD_RIGHT;      a = s_neg; b = s_neg; c = q_neg; d = q_pos; end
         ACT_SPIN_LEFT:  begin code = CMD_SPIN_LEFT;  a = s_neg; b = s_pos; c = s_neg; d = s_pos; end
         ACT_SPIN_RIGHT: begin code = CMD_SPIN_RIGHT; a = s_pos; b = s_neg; c = s_pos; d = s_neg; end
         ACT_STOP:       begin code = CMD_STOP; end
         default:        known = 1'b0;
      endcase
   end

   assign emit = line_cmd.fire && line_cmd.long_enough && known &&
                 !(line_cmd.action == last_action_ff && line_cmd.speed == last_speed_ff);

   always_comb begin
      out_valid_in   = out_valid_ff && !rsp.ready;
      code_in        = code_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      last_action_in = last_action_ff;
      last_speed_in  = last_speed_ff;
      if (emit) begin
         out_valid_in   = 1'b1;
         code_in        = code;
         a_in = a; b_in = b; c_in = c; d_in = d;
         last_action_in = line_cmd.action;
         last_speed_in  = line_cmd.speed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         last_action_ff <= ACT_STOP;
         last_speed_ff  <= 8'd0;
      end else begin
         out_valid_ff   <= out_valid_in;
         last_action_ff <= last_action_in;
         last_speed_ff  <= last_speed_in;
      end
      code_ff <= code_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.command_code  = code_ff;
   assign rsp.drive_a_speed = a_ff;
   assign rsp.drive_b_speed = b_ff;
   assign rsp.drive_c_speed = c_ff;
   assign rsp.drive_d_speed = d_ff;

`ifndef SYNTHESIS
   a_stop_is_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && code_ff == CMD_STOP) |->
      (a_ff == '0 && b_ff == '0 && c_ff == '0 && d_ff == '0))
      else $error("stop command with nonzero speed");
   a_rise_from_line: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(line_cmd.fire))
      else $error("response without a decoded line");
   a_forward_matches_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && code_ff == CMD_FORWARD) |->
      (d_ff == $signed({1'b0, last_speed_ff}) && last_action_ff == ACT_FORWARD))
      else $error("remembered command differs from response");
`endif

endmodule

>>> src/serial_motor_command_decoder_top.sv
// Top level: serial motor command decoder.
`timescale 1ns / 1ps

// Takes one received character per transfer on req_ch and emits a four-motor
// speed command on rsp_ch when a newline completes a valid, changed command
// line ("f120", ...). A character is accepted every cycle while the input
// byte register is free to move on. The response becomes valid after the
// newline transfer: the character is first held in the input byte register
// and the decoded command is then loaded into the response register. The
// response register parts the two sides, but a character held in the input
// byte register only moves on when the response slot is empty or being
// drained, so input stalls while a response waits and rsp_ch.ready is low.
module serial_motor_command_decoder_top (
   input  logic        clock,
   input  logic        reset,
   smcd_req_if.sink    req_ch,
   smcd_rsp_if.source  rsp_ch
);
   import smcd_pkg::*;

   line_cmd_type line_cmd;
   logic         mixer_ready;

   smcd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_byte    (req_ch.rx_byte),
      .in_ready   (req_ch.ready),
      .down_ready (mixer_ready),
      .line_cmd   (line_cmd)
   );

   smcd_mixer u_mixer (
      .clock    (clock),
      .reset    (reset),
      .line_cmd (line_cmd),
      .up_ready (mixer_ready),
      .rsp      (rsp_ch)
   );

endmodule
